>>> src/dma_stride_wrap_encode_check_top_macros.svh
// ------------------------------------------------------------------------
// dma_stride_wrap_encode_check_top_macros.svh
// Assertion macros used by the checker file dswec_checker.sv.
// ------------------------------------------------------------------------
`ifndef DMA_STRIDE_WRAP_ENCODE_CHECK_TOP_MACROS_SVH
`define DMA_STRIDE_WRAP_ENCODE_CHECK_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define DSWEC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DSWEC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/dswec_pkg.sv
// ------------------------------------------------------------------------
// dswec_pkg
// Types and constants of the DMA stride/wrap encoder and checker.
// ------------------------------------------------------------------------
package dswec_pkg;

	localparam int SIZE_W   = 32;
	localparam int EW_W     = 7;
	localparam int GL_W     = 3;
	localparam int MASK_W   = (1 << GL_W) - 1;
	localparam int PROD_W   = SIZE_W + EW_W;
	localparam int HS0_W    = 35;
	localparam int HS_W     = 31;
	localparam int HT_W     = 34;
	localparam int STATUS_W = 4;
	localparam int DIM_W    = 2;
	localparam int NDIM     = 4;

	localparam logic [GL_W-1:0] GL_RESET = 3'd5;

	localparam int STEP_LOG2_SHIM = 20;
	localparam int STEP_LOG2_MEM  = 17;
	localparam int STEP_LOG2_CORE = 13;
	localparam int WRAP_LOG2_SHIM = 10;
	localparam int WRAP_LOG2_MEM  = 10;
	localparam int WRAP_LOG2_CORE = 8;
	localparam int ITER_LOG2      = 6;
	localparam int ITER_SIZE_MAX  = (1 << ITER_LOG2) + 1;

	typedef enum logic [1:0] {
		TILE_SHIM = 2'd0,
		TILE_MEM  = 2'd1,
		TILE_CORE = 2'd2,
		TILE_NONE = 2'd3
	} tile_kind_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK            = 4'd0,
		ST_TILE          = 4'd1,
		ST_SIZE_NONPOS   = 4'd2,
		ST_SIZE0_ALIGN   = 4'd3,
		ST_STRIDE_NONPOS = 4'd4,
		ST_STRIDE3_NEG   = 4'd5,
		ST_STRIDE_ALIGN  = 4'd6,
		ST_SIZE0_RANGE   = 4'd7,
		ST_SIZE1_RANGE   = 4'd8,
		ST_SIZE3_RANGE   = 4'd9,
		ST_STRIDE_RANGE  = 4'd10,
		ST_STRIDE3_RANGE = 4'd11
	} status_e;

	typedef struct packed {
		logic signed [SIZE_W-1:0] size_d0;
		logic signed [SIZE_W-1:0] size_d1;
		logic signed [SIZE_W-1:0] size_d2;
		logic signed [SIZE_W-1:0] size_d3;
		logic signed [SIZE_W-1:0] stride_d0;
		logic signed [SIZE_W-1:0] stride_d1;
		logic signed [SIZE_W-1:0] stride_d2;
		logic signed [SIZE_W-1:0] stride_d3;
		logic [EW_W-1:0]          elem_width;
		logic [1:0]               tile_kind;
	} req_t;

	typedef struct packed {
		logic [HS0_W-1:0]    hw_size_d0;
		logic [HS_W-1:0]     hw_size_d1;
		logic [HS_W-1:0]     hw_size_d2;
		logic [HS_W-1:0]     hw_size_d3;
		logic [HT_W-1:0]     hw_stride_d0;
		logic [HT_W-1:0]     hw_stride_d1;
		logic [HT_W-1:0]     hw_stride_d2;
		logic [HT_W-1:0]     hw_stride_d3;
		logic [STATUS_W-1:0] status;
		logic [DIM_W-1:0]    error_dim;
	} desc_t;

	// encoder to checker
	typedef struct packed {
		logic [PROD_W-1:0]            hs0;
		logic [NDIM-1:0][PROD_W-1:0]  ht;
		logic                         mis_sz0;
		logic [NDIM-1:0]              mis_st;
	} enc_t;

endpackage

>>> src/dswec_if.sv
// ------------------------------------------------------------------------
// dswec_if
// Valid/ready channels: request, descriptor and configuration.
// ------------------------------------------------------------------------
interface dswec_req_if import dswec_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dswec_desc_if import dswec_pkg::*; ();
	logic  valid;
	logic  ready;
	desc_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dswec_cfg_if import dswec_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [GL_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/dswec_encode.sv
// ------------------------------------------------------------------------
// dswec_encode
// Element-to-granule scaling of sizes and strides, alignment flags.
// ------------------------------------------------------------------------
module dswec_encode import dswec_pkg::*; (
	input  req_t            req,
	input  logic [GL_W-1:0] gl,
	output enc_t            enc
);

	logic signed [SIZE_W-1:0] st_v [NDIM];
	logic signed [SIZE_W-1:0] sz_v [NDIM];
	logic signed [EW_W:0]     ew_s;
	logic signed [PROD_W-1:0] p_sz0;
	logic signed [PROD_W-1:0] p_st [NDIM];
	logic signed [PROD_W-1:0] q_st [NDIM];
	logic [PROD_W-1:0]        step [NDIM];
	logic [MASK_W-1:0]        gmask;

	assign st_v[0] = req.stride_d0;
	assign st_v[1] = req.stride_d1;
	assign st_v[2] = req.stride_d2;
	assign st_v[3] = req.stride_d3;
	assign sz_v[0] = req.size_d0;
	assign sz_v[1] = req.size_d1;
	assign sz_v[2] = req.size_d2;
	assign sz_v[3] = req.size_d3;

	assign ew_s  = $signed({1'b0, req.elem_width});
	assign gmask = MASK_W'(({1'b0, MASK_W'(0)} | (MASK_W+1)'(1)) << gl) - MASK_W'(1);
	assign p_sz0 = req.size_d0 * ew_s;

	always_comb begin
		for (int i = 0; i < NDIM; i++) begin
			p_st[i] = st_v[i] * ew_s;
			q_st[i] = p_st[i] >>> gl;
			// floor(p/g) - 1, zero when not above zero
			if (!q_st[i][PROD_W-1] && (q_st[i] != '0)) begin
				step[i] = PROD_W'(q_st[i]) - PROD_W'(1);
			end else begin
				step[i] = '0;
			end
			enc.mis_st[i] = |(p_st[i][MASK_W-1:0] & gmask);
		end
		enc.hs0     = PROD_W'(p_sz0 >>> gl);
		enc.mis_sz0 = |(p_sz0[MASK_W-1:0] & gmask);
		enc.ht[0]   = step[0];
		for (int i = 1; i < NDIM; i++) begin
			enc.ht[i] = (sz_v[i] > 32'sd1) ? step[i] : '0;
		end
		if (st_v[3] <= 32'sd0) begin
			enc.ht[3] = '0;
		end
	end

endmodule

>>> src/dswec_check.sv
// ------------------------------------------------------------------------
// dswec_check
// Tile limit checks, status priority and descriptor assembly.
// ------------------------------------------------------------------------
module dswec_check import dswec_pkg::*; (
	input  req_t  req,
	input  enc_t  enc,
	output desc_t desc
);

	logic [PROD_W-1:0] wrap_max;
	logic [PROD_W-1:0] step_max;
	logic              tile_ok;
	logic              linear;
	status_e           st;
	logic [DIM_W-1:0]  dim;

	always_comb begin
		tile_ok  = 1'b1;
		wrap_max = '0;
		step_max = '0;
		case (tile_kind_e'(req.tile_kind))
			TILE_SHIM: begin
				wrap_max = (PROD_W'(1) << WRAP_LOG2_SHIM) - PROD_W'(1);
				step_max = PROD_W'(1) << STEP_LOG2_SHIM;
			end
			TILE_MEM: begin
				wrap_max = (PROD_W'(1) << WRAP_LOG2_MEM) - PROD_W'(1);
				step_max = PROD_W'(1) << STEP_LOG2_MEM;
			end
			TILE_CORE: begin
				wrap_max = (PROD_W'(1) << WRAP_LOG2_CORE) - PROD_W'(1);
				step_max = PROD_W'(1) << STEP_LOG2_CORE;
			end
			default: begin
				tile_ok = 1'b0;
			end
		endcase
	end

	assign linear = (req.size_d1 == 32'sd1) && (req.size_d2 == 32'sd1) &&
		(req.size_d3 == 32'sd1) && (req.stride_d0 == 32'sd1) &&
		(req.stride_d1 == 32'sd0) && (req.stride_d2 == 32'sd0) &&
		(req.stride_d3 == 32'sd0);

	always_comb begin
		st  = ST_OK;
		dim = 2'd0;
		if (!tile_ok) begin
			st = ST_TILE;
		end else if (req.size_d0 <= 32'sd0) begin
			st = ST_SIZE_NONPOS; dim = 2'd0;
		end else if (req.size_d1 <= 32'sd0) begin
			st = ST_SIZE_NONPOS; dim = 2'd1;
		end else if (req.size_d2 <= 32'sd0) begin
			st = ST_SIZE_NONPOS; dim = 2'd2;
		end else if (req.size_d3 <= 32'sd0) begin
			st = ST_SIZE_NONPOS; dim = 2'd3;
		end else if (enc.mis_sz0) begin
			st = ST_SIZE0_ALIGN;
		end else if (linear) begin
			st = ST_OK;
		end else if (req.size_d0 > 32'sd1 && req.stride_d0 < 32'sd1) begin
			st = ST_STRIDE_NONPOS; dim = 2'd0;
		end else if (req.size_d1 > 32'sd1 && req.stride_d1 < 32'sd1) begin
			st = ST_STRIDE_NONPOS; dim = 2'd1;
		end else if (req.size_d2 > 32'sd1 && req.stride_d2 < 32'sd1) begin
			st = ST_STRIDE_NONPOS; dim = 2'd2;
		end else if (req.size_d3 > 32'sd1 && req.stride_d3 < 32'sd0) begin
			st = ST_STRIDE3_NEG; dim = 2'd3;
		end else if (enc.mis_st[0] && req.stride_d0 != 32'sd1) begin
			st = ST_STRIDE_ALIGN; dim = 2'd0;
		end else if (enc.mis_st[1]) begin
			st = ST_STRIDE_ALIGN; dim = 2'd1;
		end else if (enc.mis_st[2]) begin
			st = ST_STRIDE_ALIGN; dim = 2'd2;
		end else if (enc.mis_st[3]) begin
			st = ST_STRIDE_ALIGN; dim = 2'd3;
		end else if (enc.hs0 > wrap_max) begin
			st = ST_SIZE0_RANGE; dim = 2'd0;
		end else if (PROD_W'(req.size_d1) > wrap_max) begin
			st = ST_SIZE1_RANGE; dim = 2'd1;
		end else if (req.size_d3 > $signed(SIZE_W'(ITER_SIZE_MAX))) begin
			st = ST_SIZE3_RANGE; dim = 2'd3;
		end else if (enc.ht[0] > step_max) begin
			st = ST_STRIDE_RANGE; dim = 2'd0;
		end else if (enc.ht[1] > step_max) begin
			st = ST_STRIDE_RANGE; dim = 2'd1;
		end else if (enc.ht[2] > step_max) begin
			st = ST_STRIDE_RANGE; dim = 2'd2;
		end else if (enc.ht[3] > step_max) begin
			st = ST_STRIDE3_RANGE; dim = 2'd3;
		end
	end

	always_comb begin
		desc = '0;
		desc.status    = st;
		desc.error_dim = dim;
		if (st == ST_OK) begin
			desc.hw_size_d0   = enc.hs0[HS0_W-1:0];
			desc.hw_size_d1   = req.size_d1[HS_W-1:0];
			desc.hw_size_d2   = req.size_d2[HS_W-1:0];
			desc.hw_size_d3   = (req.size_d3 > 32'sd1) ?
				HS_W'(req.size_d3 - 32'sd1) : '0;
			desc.hw_stride_d0 = enc.ht[0][HT_W-1:0];
			desc.hw_stride_d1 = enc.ht[1][HT_W-1:0];
			desc.hw_stride_d2 = enc.ht[2][HT_W-1:0];
			desc.hw_stride_d3 = enc.ht[3][HT_W-1:0];
		end
	end

endmodule

>>> src/dma_stride_wrap_encode_check_top.sv
// ------------------------------------------------------------------------
// dma_stride_wrap_encode_check_top
// Four-dimension DMA request to descriptor encoder with tile limit check.
// ------------------------------------------------------------------------
// Takes one request word per cycle while req.ready is high: each is held
// in an input register, scaled and checked in one pass, and its descriptor
// word lands in a result register. Throughput is one word per clock while
// desc.ready is high; the result register frees as it is taken, so a
// stalled output holds at most two words before req.ready drops.
// granularity_log2 resets to 5 (32-bit granules); the user writes it
// through cfg only while no word is in flight, not enforced by the block.
module dma_stride_wrap_encode_check_top import dswec_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	dswec_req_if.sink     req,
	dswec_desc_if.source  desc,
	dswec_cfg_if.sink     cfg
);

	logic [GL_W-1:0] gran_log2_q;
	req_t            req_s1;
	logic            valid_s1;
	desc_t           desc_s2;
	logic            valid_s2;
	logic            adv_s2;
	enc_t            enc;
	desc_t           res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gran_log2_q <= GL_RESET;
		end else if (cfg.valid && cfg.ready) begin
			gran_log2_q <= cfg.data;
		end
	end

	assign adv_s2    = !valid_s2 || desc.ready;
	assign req.ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
		if (adv_s2 && valid_s1) begin
			desc_s2 <= res;
		end
	end

	dswec_encode u_encode (
		.req (req_s1),
		.gl  (gran_log2_q),
		.enc (enc)
	);

	dswec_check u_check (
		.req  (req_s1),
		.enc  (enc),
		.desc (res)
	);

	assign desc.valid = valid_s2;
	assign desc.data  = desc_s2;

endmodule

>>> src/dswec_checker.sv
// ------------------------------------------------------------------------
// dswec_checker
// Port-level checks on the descriptor channel, bound to the top level.
// ------------------------------------------------------------------------
`include "dma_stride_wrap_encode_check_top_macros.svh"

module dswec_checker import dswec_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  desc_valid,
	input logic  desc_ready,
	input desc_t desc_data
);

	`DSWEC_ASSERT_IMP(a_err_zero, desc_valid && desc_data.status != ST_OK, desc_data.hw_size_d0 == '0 && desc_data.hw_size_d1 == '0 && desc_data.hw_size_d2 == '0 && desc_data.hw_size_d3 == '0 && desc_data.hw_stride_d0 == '0 && desc_data.hw_stride_d1 == '0 && desc_data.hw_stride_d2 == '0 && desc_data.hw_stride_d3 == '0, "fields not zero on error")
	`DSWEC_ASSERT_IMP(a_dim_zero, desc_valid && (desc_data.status == ST_OK || desc_data.status == ST_TILE || desc_data.status == ST_SIZE0_ALIGN), desc_data.error_dim == 2'd0, "error_dim set without dimension")
	`DSWEC_ASSERT_IMP(a_dim_three, desc_valid && (desc_data.status == ST_STRIDE3_NEG || desc_data.status == ST_SIZE3_RANGE || desc_data.status == ST_STRIDE3_RANGE), desc_data.error_dim == 2'd3, "outer error on wrong dimension")
	`DSWEC_ASSERT_IMP(a_status_code, desc_valid, desc_data.status <= ST_STRIDE3_RANGE, "status code out of range")
	`DSWEC_ASSERT_NXT(a_stall_hold, desc_valid && !desc_ready, desc_valid && $stable(desc_data), "stalled word changed")

endmodule

bind dma_stride_wrap_encode_check_top dswec_checker u_dswec_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.desc_valid (desc.valid),
	.desc_ready (desc.ready),
	.desc_data  (desc.data)
);
